// ----- hdl/pid_pkg.sv -----
`timescale 1ns / 1ps

package pid_pkg;

  localparam int SAMPLE_WIDTH       = 16;
  localparam int GAIN_FRACTION_BITS = 8;
  localparam int GAIN_WIDTH         = 16;
  localparam int LIMIT_WIDTH        = 31;
  localparam int MODE_WIDTH         = 4;
  localparam int DATA_WIDTH         = 32;
  localparam int CFG_INDEX_WIDTH    = 3;
  localparam int CFG_DATA_WIDTH     = 32;

  localparam int ERR_WIDTH     = SAMPLE_WIDTH + 1;
  localparam int SUM_ERR_WIDTH = SAMPLE_WIDTH + 2;
  localparam int PROD_WIDTH    = SUM_ERR_WIDTH + GAIN_WIDTH;
  localparam int TERM_WIDTH    = PROD_WIDTH - GAIN_FRACTION_BITS;
  localparam int WIDE_WIDTH    = ((TERM_WIDTH > DATA_WIDTH) ? TERM_WIDTH : DATA_WIDTH) + 4;

  localparam int IN_TDATA_WIDTH  = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_WIDTH = 2 * DATA_WIDTH;

  localparam int MODE_TRAPEZOID  = 0;
  localparam int MODE_ANTI_WINDUP = 1;
  localparam int MODE_DERIV_MEAS = 2;
  localparam int MODE_SLEW       = 3;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_KP,
    REG_KI,
    REG_KD,
    REG_INTEGRAL_LIMIT,
    REG_OUTPUT_LIMIT,
    REG_DELTA_LIMIT,
    REG_MODE
  } cfg_reg_t;

  typedef logic signed [WIDE_WIDTH-1:0] wide_t;
  typedef logic signed [DATA_WIDTH-1:0] data_t;

  function automatic data_t sat_data(input wide_t v);
    wide_t hi;
    wide_t lo;
    hi = WIDE_WIDTH'($signed({1'b0, {(DATA_WIDTH-1){1'b1}}}));
    lo = WIDE_WIDTH'($signed({1'b1, {(DATA_WIDTH-1){1'b0}}}));
    if (v > hi) begin
      return hi[DATA_WIDTH-1:0];
    end else if (v < lo) begin
      return lo[DATA_WIDTH-1:0];
    end
    return v[DATA_WIDTH-1:0];
  endfunction

  function automatic wide_t clamp_sym(input wide_t v, input logic [LIMIT_WIDTH-1:0] lim);
    wide_t l;
    l = WIDE_WIDTH'($signed({1'b0, lim}));
    if (lim == '0) begin
      return v;
    end else if (v > l) begin
      return l;
    end else if (v < -l) begin
      return -l;
    end
    return v;
  endfunction

endpackage

// ----- hdl/pid_controller_with_options.sv -----
`timescale 1ns / 1ps

// A request is held in the input register and then in the second-stage term registers; its
// result is offered from the output register on the master side. Throughput: one request
// per cycle while the master side does not stall; the gain products sit in the first stage
// and the integral, clamp and slew loop closes within the second stage. Reset (synchronous,
// active high) clears the configuration, the controller state and the pipeline valid flags.
module pid_controller_with_options (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [pid_pkg::IN_TDATA_WIDTH-1:0]   s_tdata,   // measurement, setpoint
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [pid_pkg::OUT_TDATA_WIDTH-1:0]  m_tdata,   // drive, integral_term
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pid_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [pid_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

  localparam int SW  = pid_pkg::SAMPLE_WIDTH;
  localparam int F   = pid_pkg::GAIN_FRACTION_BITS;
  localparam int EW  = pid_pkg::ERR_WIDTH;
  localparam int SEW = pid_pkg::SUM_ERR_WIDTH;
  localparam int PW  = pid_pkg::PROD_WIDTH;
  localparam int TW  = pid_pkg::TERM_WIDTH;
  localparam int WW  = pid_pkg::WIDE_WIDTH;
  localparam int DW  = pid_pkg::DATA_WIDTH;
  localparam int GW  = pid_pkg::GAIN_WIDTH;
  localparam int LW  = pid_pkg::LIMIT_WIDTH;

  // Configuration
  logic signed [GW-1:0]              kp;
  logic signed [GW-1:0]              ki;
  logic signed [GW-1:0]              kd;
  logic [LW-1:0]                     integral_limit;
  logic [LW-1:0]                     output_limit;
  logic [LW-1:0]                     delta_limit;
  logic [pid_pkg::MODE_WIDTH-1:0]    mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp             <= '0;
      ki             <= '0;
      kd             <= '0;
      integral_limit <= '0;
      output_limit   <= '0;
      delta_limit    <= '0;
      mode           <= '0;
    end else if (cfg_valid) begin
      case (pid_pkg::cfg_reg_t'(cfg_index))
        pid_pkg::REG_KP:             kp <= cfg_data[GW-1:0];
        pid_pkg::REG_KI:             ki <= cfg_data[GW-1:0];
        pid_pkg::REG_KD:             kd <= cfg_data[GW-1:0];
        pid_pkg::REG_INTEGRAL_LIMIT: integral_limit <= cfg_data[LW-1:0];
        pid_pkg::REG_OUTPUT_LIMIT:   output_limit <= cfg_data[LW-1:0];
        pid_pkg::REG_DELTA_LIMIT:    delta_limit <= cfg_data[LW-1:0];
        pid_pkg::REG_MODE:           mode <= cfg_data[pid_pkg::MODE_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  // Pipeline flow control
  logic v1;
  logic v2;
  logic out_en;
  logic s2_ready;
  logic s1_ready;

  assign out_en   = !m_tvalid || m_tready;
  assign s2_ready = !v2 || out_en;
  assign s1_ready = !v1 || s2_ready;
  assign s_tready = s1_ready;

  // Stage 1: input register, error and gain products
  logic signed [SW-1:0]  meas_q;
  logic signed [SW-1:0]  setp_q;
  logic signed [EW-1:0]  previous_error;
  logic signed [SW-1:0]  previous_measurement;

  logic signed [EW-1:0]  err;
  logic signed [SEW-1:0] i_sum;
  logic signed [SEW-1:0] d_diff;
  logic signed [PW-1:0]  p_prod;
  logic signed [PW-1:0]  i_prod;
  logic signed [PW-1:0]  d_prod;
  logic signed [PW-1:0]  i_shift;

  always_comb begin
    err = EW'(setp_q) - EW'(meas_q);
    if (mode[pid_pkg::MODE_TRAPEZOID]) begin
      i_sum = SEW'(previous_error) + SEW'(err);
    end else begin
      i_sum = SEW'(err);
    end
    if (mode[pid_pkg::MODE_DERIV_MEAS]) begin
      d_diff = SEW'(previous_measurement) - SEW'(meas_q);
    end else begin
      d_diff = SEW'(err) - SEW'(previous_error);
    end
    p_prod = PW'(err) * PW'(kp);
    i_prod = PW'(i_sum) * PW'(ki);
    d_prod = PW'(d_diff) * PW'(kd);
    if (mode[pid_pkg::MODE_TRAPEZOID]) begin
      i_shift = i_prod >>> (F + 1);
    end else begin
      i_shift = i_prod >>> F;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1                   <= 1'b0;
      previous_error       <= '0;
      previous_measurement <= '0;
    end else begin
      if (s1_ready) begin
        v1 <= s_tvalid;
      end
      if (v1 && s2_ready) begin
        previous_error <= err;
        if (mode[pid_pkg::MODE_DERIV_MEAS]) begin
          previous_measurement <= meas_q;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s_tvalid) begin
      meas_q <= s_tdata[SW-1:0];
      setp_q <= s_tdata[2*SW-1:SW];
    end
  end

  // Stage 2: integral, anti-windup, output clamp and slew loop
  logic signed [TW-1:0] p_term;
  logic signed [TW-1:0] i_step;
  logic signed [TW-1:0] d_term;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (s2_ready) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1 && s2_ready) begin
      p_term <= TW'(p_prod >>> F);
      i_step <= TW'(i_shift);
      d_term <= TW'(d_prod >>> F);
    end
  end

  pid_pkg::data_t integral_accumulator;
  pid_pkg::data_t previous_output;
  pid_pkg::data_t drive;
  pid_pkg::data_t integral_term;

  pid_pkg::data_t i_sat;
  pid_pkg::wide_t i_clamped;
  pid_pkg::wide_t abs_prev;
  pid_pkg::wide_t ten_abs;
  pid_pkg::wide_t out_lim;
  pid_pkg::wide_t nine_lim;
  pid_pkg::wide_t slew_lim;
  pid_pkg::wide_t diff;
  pid_pkg::wide_t out_clamped;
  logic           freeze;
  pid_pkg::data_t integral_next;
  pid_pkg::data_t pi_sum;
  pid_pkg::data_t pid_sum;
  pid_pkg::data_t drive_next;

  always_comb begin
    i_sat     = pid_pkg::sat_data(WW'(integral_accumulator) + WW'(i_step));
    i_clamped = pid_pkg::clamp_sym(WW'(i_sat), integral_limit);

    if (previous_output < 0) begin
      abs_prev = -WW'(previous_output);
    end else begin
      abs_prev = WW'(previous_output);
    end
    ten_abs  = (abs_prev <<< 3) + (abs_prev <<< 1);
    out_lim  = WW'($signed({1'b0, output_limit}));
    nine_lim = (out_lim <<< 3) + out_lim;
    freeze   = mode[pid_pkg::MODE_ANTI_WINDUP] && (output_limit != '0) && (ten_abs >= nine_lim);

    if (freeze) begin
      integral_next = integral_accumulator;
    end else begin
      integral_next = i_clamped[DW-1:0];
    end

    pi_sum      = pid_pkg::sat_data(WW'(p_term) + WW'(integral_next));
    pid_sum     = pid_pkg::sat_data(WW'(pi_sum) + WW'(d_term));
    out_clamped = pid_pkg::clamp_sym(WW'(pid_sum), output_limit);

    slew_lim = WW'($signed({1'b0, delta_limit}));
    diff     = WW'(previous_output) - out_clamped;
    if (!mode[pid_pkg::MODE_SLEW]) begin
      drive_next = out_clamped[DW-1:0];
    end else if (diff > slew_lim) begin
      drive_next = pid_pkg::sat_data(WW'(previous_output) - slew_lim);
    end else if (diff < -slew_lim) begin
      drive_next = pid_pkg::sat_data(WW'(previous_output) + slew_lim);
    end else begin
      drive_next = out_clamped[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid             <= 1'b0;
      integral_accumulator <= '0;
      previous_output      <= '0;
    end else begin
      if (out_en) begin
        m_tvalid <= v2;
      end
      if (v2 && out_en) begin
        integral_accumulator <= integral_next;
        previous_output      <= drive_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && out_en) begin
      drive         <= drive_next;
      integral_term <= integral_next;
    end
  end

  assign m_tdata = {integral_term, drive};

`ifndef NO_ASSERTIONS
  // A stalled input side means every stage holds a request.
  assert property (@(posedge clk) disable iff (rst) !s_tready |-> (v1 && v2 && m_tvalid))
    else $error("input stalled while the pipeline has a free stage");

  // A new result only appears when the second stage held a request.
  assert property (@(posedge clk) disable iff (rst) $rose(m_tvalid) |-> $past(v2))
    else $error("result offered without a request in the second stage");

  // The fed-back output equals the result on offer.
  assert property (@(posedge clk) disable iff (rst) m_tvalid |-> (previous_output == drive))
    else $error("stored output differs from the offered drive");

  // The stored integral equals the integral on offer.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (integral_accumulator == integral_term))
    else $error("stored integral differs from the offered integral term");

  // Reset empties the pipeline.
  assert property (@(posedge clk) rst |=> (!m_tvalid && !v1 && !v2))
    else $error("pipeline not empty after reset");
`endif

endmodule

// ----- tb/sv/pid_controller_with_options_tb.sv -----
`timescale 1ns / 1ps

module pid_controller_with_options_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 300;
  localparam int MW          = pid_pkg::MODE_WIDTH;
  localparam int FB          = pid_pkg::GAIN_FRACTION_BITS;

  localparam logic [pid_pkg::CFG_INDEX_WIDTH-1:0] REG_UNUSED = 3'd7;

  localparam logic [MW-1:0] M_NONE  = '0;
  localparam logic [MW-1:0] M_TRAP  = MW'(1 << pid_pkg::MODE_TRAPEZOID);
  localparam logic [MW-1:0] M_AW    = MW'(1 << pid_pkg::MODE_ANTI_WINDUP);
  localparam logic [MW-1:0] M_DMEAS = MW'(1 << pid_pkg::MODE_DERIV_MEAS);
  localparam logic [MW-1:0] M_SLEW  = MW'(1 << pid_pkg::MODE_SLEW);
  localparam logic [MW-1:0] M_ALL   = M_TRAP | M_AW | M_DMEAS | M_SLEW;

  typedef struct packed {
    pid_pkg::data_t drive;
    pid_pkg::data_t integral;
  } pid_result_t;

  logic                                 clk;
  logic                                 rst       = 1'b1;
  logic                                 s_tvalid  = 1'b0;
  logic                                 s_tready;
  logic [pid_pkg::IN_TDATA_WIDTH-1:0]   s_tdata   = '0;
  logic                                 m_tvalid;
  logic                                 m_tready  = 1'b0;
  logic [pid_pkg::OUT_TDATA_WIDTH-1:0]  m_tdata;
  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  logic [pid_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index = '0;
  logic [pid_pkg::CFG_DATA_WIDTH-1:0]   cfg_data  = '0;

  pid_result_t expected_q[$];
  pid_result_t want;
  int          fail_count  = 0;
  int          cycle_count = 0;
  int          hold_cycles = 0;
  bit          tx_idle_on  = 1'b1;
  bit          rx_idle_on  = 1'b1;

  longint gain_p = 0, gain_i = 0, gain_d = 0;
  longint lim_integ = 0, lim_out = 0, lim_delta = 0;
  logic [MW-1:0] mode_bits = '0;

  longint last_error = 0, integ_acc = 0, last_meas = 0, last_drive = 0;

  pid_controller_with_options dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp_mag(input longint v, input longint lim);
    if (lim == 0) return v;
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic pid_result_t pid_predict(input logic [15:0] meas_raw,
                                              input logic [15:0] setp_raw);
    longint meas, err, prev_e, old_i, i_val, p_val, d_val, sum, mag, diff;
    pid_result_t r;
    meas = longint'($signed(meas_raw));
    err = longint'($signed(setp_raw)) - meas;
    prev_e = last_error;
    last_error = err;
    p_val = (err * gain_p) >>> FB;
    old_i = integ_acc;
    if (mode_bits[pid_pkg::MODE_TRAPEZOID]) begin
      i_val = sat32(old_i + (((prev_e + err) * gain_i) >>> (FB + 1)));
    end else begin
      i_val = sat32(old_i + ((err * gain_i) >>> FB));
    end
    i_val = clamp_mag(i_val, lim_integ);
    if (mode_bits[pid_pkg::MODE_ANTI_WINDUP] && lim_out != 0) begin
      mag = (last_drive < 0) ? -last_drive : last_drive;
      if (10 * mag >= 9 * lim_out) i_val = old_i;
    end
    integ_acc = i_val;
    if (mode_bits[pid_pkg::MODE_DERIV_MEAS]) begin
      d_val = ((last_meas - meas) * gain_d) >>> FB;
      last_meas = meas;
    end else begin
      d_val = ((err - prev_e) * gain_d) >>> FB;
    end
    sum = sat32(sat32(p_val + i_val) + d_val);
    sum = clamp_mag(sum, lim_out);
    if (mode_bits[pid_pkg::MODE_SLEW]) begin
      diff = last_drive - sum;
      if (diff > lim_delta) begin
        sum = last_drive - lim_delta;
      end else if (diff < -lim_delta) begin
        sum = last_drive + lim_delta;
      end
      sum = sat32(sum);
    end
    last_drive = sum;
    r.drive = pid_pkg::data_t'(sum);
    r.integral = pid_pkg::data_t'(i_val);
    return r;
  endfunction

  function automatic void check_field(input string name, input pid_pkg::data_t exp_v,
                                      input pid_pkg::data_t got_v);
    if (exp_v !== got_v) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("result with nothing pending: drive %0d, integral %0d",
                   $signed(m_tdata[31:0]), $signed(m_tdata[63:32]));
        end
      end else begin
        want = expected_q.pop_front();
        check_field("drive", want.drive, m_tdata[31:0]);
        check_field("integral", want.integral, m_tdata[63:32]);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        for (int n = 0; n < hold_cycles; n++) @(posedge clk);
        hold_cycles = 0;
        m_tready <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_sample(input logic [15:0] meas, input logic [15:0] setp);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {setp, meas};
    do @(posedge clk); while (!s_tready);
    expected_q.push_back(pid_predict(meas, setp));
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pid_pkg::CFG_INDEX_WIDTH-1:0] idx,
                           input logic [pid_pkg::CFG_DATA_WIDTH-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      pid_pkg::REG_KP:             gain_p = longint'($signed(value[15:0]));
      pid_pkg::REG_KI:             gain_i = longint'($signed(value[15:0]));
      pid_pkg::REG_KD:             gain_d = longint'($signed(value[15:0]));
      pid_pkg::REG_INTEGRAL_LIMIT: lim_integ = longint'(value[30:0]);
      pid_pkg::REG_OUTPUT_LIMIT:   lim_out = longint'(value[30:0]);
      pid_pkg::REG_DELTA_LIMIT:    lim_delta = longint'(value[30:0]);
      pid_pkg::REG_MODE:           mode_bits = value[3:0];
      default: ;
    endcase
  endtask

  // Unused upper bits carry junk, and the spare index is written too.
  task automatic apply_settings(input logic [15:0] kp, input logic [15:0] ki,
                                input logic [15:0] kd, input logic [30:0] il,
                                input logic [30:0] ol, input logic [30:0] dl,
                                input logic [MW-1:0] md);
    drain_results();
    write_reg(REG_UNUSED, $urandom());
    write_reg(pid_pkg::REG_KP, {16'($urandom()), kp});
    write_reg(pid_pkg::REG_KI, {16'($urandom()), ki});
    write_reg(pid_pkg::REG_KD, {16'($urandom()), kd});
    write_reg(pid_pkg::REG_INTEGRAL_LIMIT, {1'($urandom()), il});
    write_reg(pid_pkg::REG_OUTPUT_LIMIT, {1'($urandom()), ol});
    write_reg(pid_pkg::REG_DELTA_LIMIT, {1'($urandom()), dl});
    write_reg(pid_pkg::REG_MODE, {28'($urandom()), md});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] random_gain();
    case ($urandom_range(0, 3))
      0: return 16'($urandom());
      1: return 16'($urandom_range(0, 1023) - 512);
      2: return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
      default: return 16'($urandom_range(0, 511));
    endcase
  endfunction

  function automatic logic [30:0] random_limit();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 31'($urandom_range(1, 100000));
      2: return 31'($urandom());
      3: return 31'h7FFF_FFFF;
      default: return 31'($urandom_range(1, 20000000));
    endcase
  endfunction

  function automatic logic [15:0] random_sample();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 255) - 128);
      1: return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic apply_random_settings();
    apply_settings(random_gain(), random_gain(), random_gain(), random_limit(),
                   random_limit(), random_limit(), MW'($urandom()));
  endtask

  task automatic send_random_sample();
    logic [15:0] setp;
    setp = random_sample();
    if ($urandom_range(0, 2) == 0) begin
      send_sample(setp + 16'($urandom_range(0, 31) - 16), setp);
    end else begin
      send_sample(random_sample(), setp);
    end
  endtask

  task automatic test_reset_state();
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h8000, 16'h7FFF);
    send_sample(16'h0000, 16'h0000);
  endtask

  // The freeze condition is met with equality at a limit of 1000 and missed at 1001.
  task automatic test_anti_windup_boundary();
    apply_settings(16'd0, 16'd256, 16'd0, 31'd0, 31'd1000, 31'd0, M_AW);
    send_sample(16'd0, 16'd900);
    send_sample(16'd0, 16'd10);
    apply_settings(16'd0, 16'd256, 16'd0, 31'd0, 31'd1001, 31'd0, M_AW);
    send_sample(16'd0, 16'd10);
  endtask

  task automatic test_gain_extremes();
    apply_settings(16'h7FFF, 16'h8000, 16'h7FFF, 31'd0, 31'd0, 31'd0, M_NONE);
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h8000, 16'h7FFF);
    send_sample(16'h0000, 16'h0000);
    send_sample(16'hFFFF, 16'hFFFF);
    send_sample(16'h8000, 16'h8000);
    apply_settings(16'h8000, 16'h7FFF, 16'h8000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                   31'h7FFF_FFFF, M_ALL);
    send_sample(16'h8000, 16'h7FFF);
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h1234, 16'hEDCB);
  endtask

  task automatic test_trapezoid_rounding();
    apply_settings(16'd256, 16'd1, 16'd256, 31'd0, 31'd0, 31'd0, M_TRAP);
    send_sample(16'd1, 16'd0);
    send_sample(16'd1, 16'd0);
    send_sample(16'd0, 16'd1);
    send_sample(16'd3, 16'd0);
  endtask

  // The stored measurement must stay put while the mode is off.
  task automatic test_measurement_derivative();
    apply_settings(16'd0, 16'd0, 16'd300, 31'd0, 31'd0, 31'd0, M_DMEAS);
    send_sample(16'd100, 16'd0);
    send_sample(16'hFF38, 16'd0);
    apply_settings(16'd0, 16'd0, 16'd300, 31'd0, 31'd0, 31'd0, M_NONE);
    send_sample(16'd50, 16'd0);
    apply_settings(16'd0, 16'd0, 16'd300, 31'd0, 31'd0, 31'd0, M_DMEAS);
    send_sample(16'd10, 16'd0);
  endtask

  task automatic test_slew_and_clamps();
    apply_settings(16'd512, 16'd100, 16'd0, 31'd1, 31'd50, 31'd0, M_SLEW);
    send_sample(16'h8000, 16'h7FFF);
    send_sample(16'h7FFF, 16'h8000);
    apply_settings(16'd512, 16'd100, 16'd0, 31'd1, 31'd50, 31'd1, M_SLEW);
    send_sample(16'h8000, 16'h7FFF);
    send_sample(16'h7FFF, 16'h8000);
  endtask

  task automatic test_integral_saturation();
    apply_settings(16'h7FFF, 16'h7FFF, 16'h7FFF, 31'd0, 31'd0, 31'd0, M_NONE);
    repeat (270) begin
      send_sample(16'h8000 | 16'($urandom_range(0, 15)),
                  16'h7FFF - 16'($urandom_range(0, 15)));
    end
  endtask

  // The receiver holds off while requests keep coming, so the block backs up.
  task automatic test_output_stall();
    tx_idle_on = 1'b0;
    apply_random_settings();
    hold_cycles = LONG_HOLD;
    repeat (40) send_random_sample();
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_settings(input int phases, input int items);
    repeat (phases) begin
      apply_random_settings();
      repeat (items) send_random_sample();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_anti_windup_boundary();
    test_gain_extremes();
    test_trapezoid_rounding();
    test_measurement_derivative();
    test_slew_and_clamps();
    test_integral_saturation();
    test_output_stall();
    test_random_settings(4, 35);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random_settings(2, 35);
    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
